@@ rtl/core/button_click_classifier_defines.svh @@
// Assertion macros shared by the button click classifier RTL.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bcc_pkg.sv @@
// Package with the codes, widths and reset constants of the button click classifier.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int CountW = 8;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW = 8;

  typedef logic [CountW-1:0] count_t;
  typedef logic [1:0] phase_t;
  typedef logic [1:0] event_t;

  // Lower stage phases.
  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_DEBOUNCE = 2'd1;
  localparam phase_t PH_TIMING = 2'd2;
  localparam phase_t PH_WAIT_RELEASE = 2'd3;

  // Event codes on the result channel.
  localparam event_t EV_NONE = 2'd0;
  localparam event_t EV_SINGLE = 2'd1;
  localparam event_t EV_DOUBLE = 2'd2;
  localparam event_t EV_LONG = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_DOUBLE_WINDOW = 2'd1;

  // Register reset values.
  localparam count_t LONG_PRESS_RESET = 8'd100;
  localparam count_t DOUBLE_WINDOW_RESET = 8'd25;

  localparam count_t COUNT_MAX = '1;

endpackage

`default_nettype wire

@@ rtl/core/button_click_classifier.sv @@
// Top level of the button click classifier: debounce, press timing and click pairing.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one sampled button level per item (in_pressed, 1 means
// pressed) and returns exactly one event code per item: 0 none, 1 single
// click, 2 double click, 3 long press. A press counts once it is seen on two
// items in a row. Releasing before the long press limit gives a short press,
// and holding until the hold count reaches long_press_ticks gives a long
// press at once. A short press is held back for up to
// double_click_window_ticks items: a second short press in that window turns
// into a double click, otherwise the held press comes out as a single click.
// A long press that arrives while a short press is held back is dropped.
// A register written as zero behaves like one. The block accepts one item in
// every cycle while in_stall is low; the whole state update is one
// combinational step between the state registers, and the event is
// registered in the output register, or in the skid register while the
// output register stalls. A two-entry output buffer (output register plus
// skid register) keeps the input side moving while the output side stalls;
// in_stall rises only when both entries are full. Configuration writes are
// always ready and take effect at once; they should be made only while no
// item is in flight. Writes to an index other than 0 or 1 are ignored.
module button_click_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_pressed,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_event_code,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bcc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bcc_pkg::CfgDataW-1:0]  cfg_data
);

  // Configuration registers.
  bcc_pkg::count_t long_press_r;
  bcc_pkg::count_t double_window_r;

  // Classifier state.
  bcc_pkg::phase_t press_phase_r, press_phase_nxt;
  bcc_pkg::count_t hold_count_r, hold_count_nxt;
  logic            click_waiting_r, click_waiting_nxt;
  bcc_pkg::count_t gap_count_r, gap_count_nxt;

  // Output buffer.
  logic            out_valid_r, out_valid_nxt;
  bcc_pkg::event_t out_event_r, out_event_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  bcc_pkg::event_t skid_event_r, skid_event_nxt;

  logic            accept;
  logic            out_take;
  bcc_pkg::event_t low_event;
  bcc_pkg::event_t item_event;
  bcc_pkg::count_t hold_inc;
  bcc_pkg::count_t gap_inc;

  // The input side stalls only when both output entries hold events.
  assign in_stall = skid_valid_r;
  assign accept = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign out_valid = out_valid_r;
  assign out_event_code = out_event_r;
  assign cfg_ready = 1'b1;

  // Saturating increments; the counts never wrap.
  assign hold_inc = (hold_count_r == bcc_pkg::COUNT_MAX) ? hold_count_r
                                                         : hold_count_r + 8'd1;
  assign gap_inc = (gap_count_r == bcc_pkg::COUNT_MAX) ? gap_count_r
                                                       : gap_count_r + 8'd1;

  // Lower stage: debounce and press timing. It reports a short press with the
  // single click code and a long press with the long press code.
  always_comb begin
    press_phase_nxt = press_phase_r;
    hold_count_nxt = hold_count_r;
    low_event = bcc_pkg::EV_NONE;
    case (press_phase_r)
      bcc_pkg::PH_IDLE: begin
        if (in_pressed) begin
          press_phase_nxt = bcc_pkg::PH_DEBOUNCE;
        end
      end
      bcc_pkg::PH_DEBOUNCE: begin
        if (in_pressed) begin
          hold_count_nxt = '0;
          press_phase_nxt = bcc_pkg::PH_TIMING;
        end else begin
          press_phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
      bcc_pkg::PH_TIMING: begin
        if (!in_pressed) begin
          low_event = bcc_pkg::EV_SINGLE;
          press_phase_nxt = bcc_pkg::PH_IDLE;
        end else begin
          hold_count_nxt = hold_inc;
          // The compare uses the count after the increment, so a zero limit
          // fires on the first counted item just like a limit of one.
          if (hold_inc >= long_press_r) begin
            low_event = bcc_pkg::EV_LONG;
            press_phase_nxt = bcc_pkg::PH_WAIT_RELEASE;
          end
        end
      end
      default: begin
        if (!in_pressed) begin
          press_phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Upper stage: hold a short press back to pair it with a second one.
  always_comb begin
    click_waiting_nxt = click_waiting_r;
    gap_count_nxt = gap_count_r;
    item_event = bcc_pkg::EV_NONE;
    if (!click_waiting_r) begin
      if (low_event == bcc_pkg::EV_SINGLE) begin
        gap_count_nxt = '0;
        click_waiting_nxt = 1'b1;
      end else begin
        item_event = low_event;
      end
    end else begin
      if (low_event == bcc_pkg::EV_SINGLE) begin
        item_event = bcc_pkg::EV_DOUBLE;
        click_waiting_nxt = 1'b0;
      end else begin
        // A long press while a click is held is dropped, but its item still
        // advances the gap count.
        gap_count_nxt = gap_inc;
        if (gap_inc >= double_window_r) begin
          item_event = bcc_pkg::EV_SINGLE;
          click_waiting_nxt = 1'b0;
        end
      end
    end
  end

  // Output buffer: the output register refills from the skid register first,
  // then from the new item; a new item lands in the skid register while the
  // output register is stalled.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_event_nxt = out_event_r;
    skid_valid_nxt = skid_valid_r;
    skid_event_nxt = skid_event_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt = 1'b1;
        out_event_nxt = skid_event_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_event_nxt = item_event;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_event_nxt = item_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= bcc_pkg::LONG_PRESS_RESET;
      double_window_r <= bcc_pkg::DOUBLE_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcc_pkg::REG_LONG_PRESS: long_press_r <= cfg_data;
        bcc_pkg::REG_DOUBLE_WINDOW: double_window_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_phase_r <= bcc_pkg::PH_IDLE;
      hold_count_r <= '0;
      click_waiting_r <= 1'b0;
      gap_count_r <= '0;
    end else if (accept) begin
      press_phase_r <= press_phase_nxt;
      hold_count_r <= hold_count_nxt;
      click_waiting_r <= click_waiting_nxt;
      gap_count_r <= gap_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_event_r <= out_event_nxt;
    skid_event_r <= skid_event_nxt;
  end

`include "button_click_classifier_defines.svh"

  `BCC_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full while output empty")
  `BCC_ASSERT_NEXT(a_stalled_accept_fills_skid, accept && out_valid_r && out_stall, skid_valid_r, "item lost under stall")
  `BCC_ASSERT_NEXT(a_drain_empties_out, out_take && !accept && !skid_valid_r, !out_valid_r, "event repeated")
  `BCC_ASSERT_NEXT(a_accept_fills_out, accept, out_valid_r, "accepted item gave no event")

endmodule

`default_nettype wire
